/* sv/mse_pkg.sv */
package mse_pkg;

  // table and field sizes
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 5;
  localparam int TIME_W     = 32;
  localparam int VAL_W      = 24;
  localparam int RATE_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 24;

  // shared multiplier and divider sizes
  localparam int OP_W   = 34;
  localparam int PROD_W = 2 * OP_W;
  localparam int NUM_W  = 57;
  localparam int DEN_W  = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_KIND = 3'd0,
    CFG_WAVE_SHAPE  = 3'd1,
    CFG_LFO_RATE    = 3'd2,
    CFG_LFO_DEPTH   = 3'd3,
    CFG_POINT_COUNT = 3'd4
  } cfg_idx_e;

  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [1:0] WAVE_SQUARE   = 2'd2;
  localparam logic [1:0] WAVE_SAW      = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic KIND_ENV = 1'b1;

  // odd Taylor coefficients of sin(pi/2*x), Q2.30
  localparam logic signed [OP_W-1:0] SIN_A1 = 34'sd1686629713;
  localparam logic signed [OP_W-1:0] SIN_A3 = -34'sd693598668;
  localparam logic signed [OP_W-1:0] SIN_A5 = 34'sd85569306;
  localparam logic signed [OP_W-1:0] SIN_A7 = -34'sd5026995;
  localparam logic signed [OP_W-1:0] SIN_A9 = 34'sd172272;

  // Horner coefficient for step k (A7 first)
  function automatic logic signed [OP_W-1:0] sin_coef(input logic [1:0] k);
    logic signed [OP_W-1:0] c;
    case (k)
      2'd0:    c = SIN_A7;
      2'd1:    c = SIN_A5;
      2'd2:    c = SIN_A3;
      default: c = SIN_A1;
    endcase
    return c;
  endfunction

  // saturate to the signed 24-bit output range
  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'sd8388607) r = 24'sh7FFFFF;
    else if (v < -64'sd8388608) r = 24'sh800000;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

endpackage

/* sv/mse_mul.sv */
module mse_mul (
  input  logic                              clk_i,
  input  logic signed [mse_pkg::OP_W-1:0]   a_i,
  input  logic signed [mse_pkg::OP_W-1:0]   b_i,
  output logic signed [mse_pkg::PROD_W-1:0] prod_o
);
  import mse_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // one registered signed product per cycle
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

/* sv/mse_div.sv */
module mse_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mse_pkg::NUM_W-1:0]  num_i,
  input  logic [mse_pkg::DEN_W-1:0]  den_i,
  output logic                       done_o,
  output logic [mse_pkg::NUM_W-1:0]  quo_o
);
  import mse_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = CW'(NUM_W - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      if (!diff[DEN_W]) begin
        rem_d = diff[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* sv/modulation_source_eval.sv */
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   operation, point_index, point_time,
//                                              point_value, eval_time
// out       output     out_valid_o/out_ready_i mod_value
// cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A write item gives no result. After an evaluate item the block stays busy;
// a sine runs Horner steps on the shared multiplier before the depth scaling
// that all LFO shapes share. An envelope evaluate returns zero with no points,
// an end level, or the left level on a zero span, and else interpolates after
// a search of at most point_count - 2 steps and a bit-serial division.
// Reset is asynchronous, active low, and leaves the table unwritten.
// A waiting result does not block intake; a finished item holds until the
// output register is free.
module modulation_source_eval (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [mse_pkg::IDX_W-1:0]           point_index_i,
  input  logic [mse_pkg::TIME_W-1:0]          point_time_i,
  input  logic signed [mse_pkg::VAL_W-1:0]    point_value_i,
  input  logic [mse_pkg::TIME_W-1:0]          eval_time_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mse_pkg::VAL_W-1:0]    mod_value_o,
  input  logic                                cfg_we_i,
  input  logic [mse_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mse_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import mse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_L_PH, S_S_X2, S_S_HORN, S_S_FIN, S_L_DEP,
    S_E_FIRST, S_E_LAST, S_E_SRCH, S_E_LEFT, S_E_MUL, S_E_DIV, S_DONE
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic                    kind_q;
  logic [1:0]              shape_q;
  logic [RATE_W-1:0]       rate_q;
  logic signed [VAL_W-1:0] depth_q;
  logic [CNT_W-1:0]        count_q;

  // working registers
  logic [TIME_W-1:0]       t_q, t_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [30:0]             x_q, x_d;
  logic [30:0]             x2_q, x2_d;
  logic [1:0]              quad_q, quad_d;
  logic [1:0]              k_q, k_d;
  logic [TIME_W-1:0]       t1_q, t1_d;
  logic signed [VAL_W-1:0] v1_q, v1_d;
  logic signed [VAL_W-1:0] v0_q, v0_d;
  logic [DEN_W-1:0]        span_q, span_d;
  logic                    neg_q, neg_d;
  logic signed [VAL_W-1:0] res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] mod_value_q, mod_value_d;

  // table memory
  logic [TIME_W-1:0]       mem_time [MAX_POINTS];
  logic signed [VAL_W-1:0] mem_lvl  [MAX_POINTS];
  logic [TIME_W-1:0]       rd_time_q;
  logic signed [VAL_W-1:0] rd_lvl_q;
  logic [IDX_W-1:0]        rd_addr;

  // shared units
  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     div_start;
  logic [NUM_W-1:0]         div_num;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;

  logic                     in_acc;
  logic [CNT_W-1:0]         n;
  logic [IDX_W-1:0]         n_m1;

  // scratch
  logic [31:0]              u;
  logic [30:0]              r;
  logic [31:0]              dtri;
  logic signed [18:0]       w19;
  logic signed [PROD_W-1:0] sh30, sh16;
  logic signed [OP_W-1:0]   acc, s;
  logic signed [OP_W-1:0]   wsin;
  logic signed [32:0]       span_s, dt_s;
  logic signed [VAL_W:0]    dv;
  logic [PROD_W-1:0]        pmag;
  logic signed [25:0]       q_s;
  logic signed [VAL_W+1:0]  sum;

  mse_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  mse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (span_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign n          = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;
  assign n_m1       = IDX_W'(n - CNT_W'(1));

  // sequencer
  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    idx_d       = idx_q;
    x_d         = x_q;
    x2_d        = x2_q;
    quad_d      = quad_q;
    k_d         = k_q;
    t1_d        = t1_q;
    v1_d        = v1_q;
    v0_d        = v0_q;
    span_d      = span_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    mod_value_d = mod_value_q;
    mul_a       = '0;
    mul_b       = '0;
    rd_addr     = '0;
    div_start   = 1'b0;
    div_num     = '0;

    u      = prod[31:0];
    r      = {1'b0, u[29:0]};
    dtri   = u[31] ? (u - 32'h8000_0000) : (32'h8000_0000 - u);
    w19    = '0;
    sh30   = prod >>> 30;
    sh16   = prod >>> 16;
    acc    = sin_coef(k_q) + sh30[OP_W-1:0];
    s      = quad_q[1] ? -sh30[OP_W-1:0] : sh30[OP_W-1:0];
    wsin   = (s + OP_W'(8192)) >>> 14;
    span_s = $signed({1'b0, t1_q}) - $signed({1'b0, rd_time_q});
    dt_s   = $signed({1'b0, t_q}) - $signed({1'b0, rd_time_q});
    dv     = $signed({v1_q[VAL_W-1], v1_q}) - $signed({rd_lvl_q[VAL_W-1], rd_lvl_q});
    pmag   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    q_s    = neg_q ? -$signed(div_quo[25:0]) : $signed(div_quo[25:0]);
    sum    = $signed({{2{v0_q[VAL_W-1]}}, v0_q}) + q_s;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc && operation_i != OP_WRITE) begin
          t_d = eval_time_i;
          if (kind_q == KIND_ENV) begin
            if (n == '0) begin
              res_d   = '0;
              state_d = S_DONE;
            end else begin
              state_d = S_E_FIRST;
            end
          end else begin
            mul_a   = OP_W'(rate_q);
            mul_b   = OP_W'(eval_time_i);
            state_d = S_L_PH;
          end
        end
      end
      S_L_PH: begin
        quad_d = u[31:30];
        x_d    = u[30] ? (31'h4000_0000 - r) : r;
        case (shape_q)
          WAVE_SINE: begin
            mul_a   = OP_W'(u[30] ? (31'h4000_0000 - r) : r);
            mul_b   = OP_W'(u[30] ? (31'h4000_0000 - r) : r);
            state_d = S_S_X2;
          end
          WAVE_TRIANGLE: w19 = 19'sd65536 - $signed({1'b0, dtri[31:14]});
          WAVE_SQUARE:   w19 = u[31] ? -19'sd65536 : 19'sd65536;
          default:       w19 = $signed({2'b00, u[31:15]}) - 19'sd65536;
        endcase
        if (shape_q != WAVE_SINE) begin
          mul_a   = OP_W'(w19);
          mul_b   = OP_W'(depth_q);
          state_d = S_L_DEP;
        end
      end
      S_S_X2: begin
        x2_d    = sh30[30:0];
        mul_a   = SIN_A9;
        mul_b   = OP_W'(sh30[30:0]);
        k_d     = '0;
        state_d = S_S_HORN;
      end
      S_S_HORN: begin
        mul_a = acc;
        if (k_q == 2'd3) begin
          mul_b   = OP_W'(x_q);
          state_d = S_S_FIN;
        end else begin
          mul_b = OP_W'(x2_q);
          k_d   = k_q + 2'd1;
        end
      end
      S_S_FIN: begin
        mul_a   = wsin;
        mul_b   = OP_W'(depth_q);
        state_d = S_L_DEP;
      end
      S_L_DEP: begin
        res_d   = sat24(sh16[63:0]);
        state_d = S_DONE;
      end
      S_E_FIRST: begin
        if (n == CNT_W'(1) || t_q <= rd_time_q) begin
          res_d   = rd_lvl_q;
          state_d = S_DONE;
        end else begin
          rd_addr = n_m1;
          state_d = S_E_LAST;
        end
      end
      S_E_LAST: begin
        if (t_q >= rd_time_q) begin
          res_d   = rd_lvl_q;
          state_d = S_DONE;
        end else begin
          idx_d   = '0;
          rd_addr = IDX_W'(1);
          state_d = S_E_SRCH;
        end
      end
      S_E_SRCH: begin
        if ((CNT_W'(idx_q) + CNT_W'(1)) < n && rd_time_q <= t_q) begin
          idx_d   = idx_q + IDX_W'(1);
          rd_addr = idx_q + IDX_W'(2);
        end else begin
          t1_d    = rd_time_q;
          v1_d    = rd_lvl_q;
          rd_addr = idx_q;
          state_d = S_E_LEFT;
        end
      end
      S_E_LEFT: begin
        v0_d   = rd_lvl_q;
        span_d = span_s[DEN_W-1:0];
        if (span_s <= 33'sd0) begin
          res_d   = rd_lvl_q;
          state_d = S_DONE;
        end else begin
          mul_a   = OP_W'(dv);
          mul_b   = OP_W'(dt_s);
          state_d = S_E_MUL;
        end
      end
      S_E_MUL: begin
        neg_d     = prod[PROD_W-1];
        div_num   = pmag[NUM_W-1:0];
        div_start = 1'b1;
        state_d   = S_E_DIV;
      end
      S_E_DIV: begin
        if (div_done) begin
          res_d   = sat24(64'(sum));
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          mod_value_d = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state, registered output and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mod_value_q <= '0;
      kind_q      <= 1'b0;
      shape_q     <= WAVE_SINE;
      rate_q      <= RATE_W'(65536);
      depth_q     <= 24'sd65536;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      mod_value_q <= mod_value_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOURCE_KIND: kind_q  <= cfg_wdata_i[0];
          CFG_WAVE_SHAPE:  shape_q <= cfg_wdata_i[1:0];
          CFG_LFO_RATE:    rate_q  <= cfg_wdata_i;
          CFG_LFO_DEPTH:   depth_q <= $signed(cfg_wdata_i);
          CFG_POINT_COUNT: count_q <= cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q         <= t_d;
    idx_q       <= idx_d;
    x_q         <= x_d;
    x2_q        <= x2_d;
    quad_q      <= quad_d;
    k_q         <= k_d;
    t1_q        <= t1_d;
    v1_q        <= v1_d;
    v0_q        <= v0_d;
    span_q      <= span_d;
    neg_q       <= neg_d;
    res_q       <= res_d;
  end

  // breakpoint table: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == OP_WRITE) begin
      mem_time[point_index_i] <= point_time_i;
      mem_lvl[point_index_i]  <= point_value_i;
    end
    rd_time_q <= mem_time[rd_addr];
    rd_lvl_q  <= mem_lvl[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign mod_value_o = mod_value_q;

endmodule

/* tb/mse_checker.sv */
module mse_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              operation_i,
  input  logic [mse_pkg::IDX_W-1:0]         point_index_i,
  input  logic [mse_pkg::TIME_W-1:0]        point_time_i,
  input  logic signed [mse_pkg::VAL_W-1:0]  point_value_i,
  input  logic [mse_pkg::TIME_W-1:0]        eval_time_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [mse_pkg::VAL_W-1:0]  mod_value_i,
  input  logic                              cfg_we_i,
  input  logic [mse_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mse_pkg::CFG_W-1:0]         cfg_wdata_i,
  output int                                errors_o,
  output int                                pending_o
);
  import mse_pkg::*;

  // sin(pi/2*x) polynomial, Q2.30
  localparam longint K1 = 1686629713;
  localparam longint K3 = -693598668;
  localparam longint K5 = 85569306;
  localparam longint K7 = -5026995;
  localparam longint K9 = 172272;
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint HALF_TURN = 64'sd2147483648;

  logic                    src_env;
  logic [1:0]              shape;
  logic [RATE_W-1:0]       rate;
  logic signed [VAL_W-1:0] depth;
  logic [CNT_W-1:0]        count;
  logic [TIME_W-1:0]       pt_time [MAX_POINTS];
  logic signed [VAL_W-1:0] pt_level [MAX_POINTS];

  logic signed [VAL_W-1:0] mod_q[$];
  int errors = 0;

  assign errors_o  = errors;
  assign pending_o = mod_q.size();

  function automatic logic signed [VAL_W-1:0] clamp_out(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[VAL_W-1:0];
  endfunction

  function automatic longint quarter_sine(input longint x);
    longint x2, acc;
    x2  = (x * x) >>> 30;
    acc = K9;
    acc = K7 + ((acc * x2) >>> 30);
    acc = K5 + ((acc * x2) >>> 30);
    acc = K3 + ((acc * x2) >>> 30);
    acc = K1 + ((acc * x2) >>> 30);
    return (acc * x) >>> 30;
  endfunction

  // wave in Q16 for phase u (Q0.32)
  function automatic longint wave_at(input logic [31:0] u);
    longint r, s, d;
    case (shape)
      WAVE_SINE: begin
        r = longint'(u[29:0]);
        s = quarter_sine(u[30] ? Q30_ONE - r : r);
        if (u[31]) s = -s;
        return (s + 8192) >>> 14;
      end
      WAVE_TRIANGLE: begin
        d = longint'(u) - HALF_TURN;
        if (d < 0) d = -d;
        return 65536 - (d >>> 14);
      end
      WAVE_SQUARE: return (longint'(u) < HALF_TURN) ? 65536 : -65536;
      default:     return longint'(u >> 15) - 65536;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] lfo_at(input logic [31:0] t);
    logic [63:0] prod;
    prod = {40'd0, rate} * {32'd0, t};
    return clamp_out((wave_at(prod[31:0]) * longint'(depth)) >>> 16);
  endfunction

  function automatic logic signed [VAL_W-1:0] envelope_at(input logic [31:0] t);
    int n, i;
    longint t0, span, v0, dv;
    n = (count > MAX_POINTS) ? MAX_POINTS : int'(count);
    if (n == 0) return '0;
    if (n == 1 || t <= pt_time[0]) return pt_level[0];
    if (t >= pt_time[n-1]) return pt_level[n-1];
    i = 0;
    while (i + 1 < n && pt_time[i+1] <= t) i++;
    t0   = longint'(pt_time[i]);
    span = longint'(pt_time[i+1]) - t0;
    v0   = longint'(pt_level[i]);
    dv   = longint'(pt_level[i+1]) - v0;
    if (span <= 0) return pt_level[i];
    return clamp_out(v0 + (dv * (longint'(t) - t0)) / span);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_env = 1'b0;
      shape   = WAVE_SINE;
      rate    = 24'd65536;
      depth   = 24'sd65536;
      count   = '0;
      mod_q.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOURCE_KIND: src_env = cfg_wdata_i[0];
          CFG_WAVE_SHAPE:  shape   = cfg_wdata_i[1:0];
          CFG_LFO_RATE:    rate    = cfg_wdata_i[RATE_W-1:0];
          CFG_LFO_DEPTH:   depth   = cfg_wdata_i[VAL_W-1:0];
          CFG_POINT_COUNT: count   = cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      // accepted item
      if (in_valid_i && in_ready_i) begin
        if (operation_i == OP_WRITE) begin
          pt_time[point_index_i]  = point_time_i;
          pt_level[point_index_i] = point_value_i;
        end else if (src_env == KIND_ENV) begin
          mod_q.insert(mod_q.size(), envelope_at(eval_time_i));
        end else begin
          mod_q.insert(mod_q.size(), lfo_at(eval_time_i));
        end
      end
      // accepted result
      if (out_valid_i && out_ready_i) begin
        if (mod_q.size() == 0) begin
          $error("mod_value: no result expected, got %0d", mod_value_i);
          errors++;
        end else begin
          logic signed [VAL_W-1:0] want;
          want = mod_q.pop_front();
          if (mod_value_i !== want) begin
            $error("mod_value: expected %0d, got %0d", want, mod_value_i);
            errors++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_modulation_source_eval.sv */
module tb_modulation_source_eval;
  import mse_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 90;
  localparam logic OP_EVAL = 1'b1;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    operation = OP_EVAL;
  logic [IDX_W-1:0]        point_index = '0;
  logic [TIME_W-1:0]       point_time = '0;
  logic signed [VAL_W-1:0] point_value = '0;
  logic [TIME_W-1:0]       eval_time = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] mod_value;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  int                      errors, pending;
  bit                      idle_en = 1'b1;
  int                      cycles = 0;
  int                      out_stall = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modulation_source_eval i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .operation_i  (operation),
    .point_index_i(point_index),
    .point_time_i (point_time),
    .point_value_i(point_value),
    .eval_time_i  (eval_time),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .mod_value_o  (mod_value),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  mse_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .operation_i  (operation),
    .point_index_i(point_index),
    .point_time_i (point_time),
    .point_value_i(point_value),
    .eval_time_i  (eval_time),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .mod_value_i  (mod_value),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // result side back-pressure in short bursts
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one item, held until accepted
  task automatic send(input logic op, input logic [IDX_W-1:0] idx,
                      input logic [TIME_W-1:0] pt, input logic [VAL_W-1:0] pv,
                      input logic [TIME_W-1:0] et);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    point_index <= idx;
    point_time  <= pt;
    point_value <= pv;
    eval_time   <= et;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_point(input int idx, input logic [TIME_W-1:0] pt,
                             input logic [VAL_W-1:0] pv);
    send(OP_WRITE, idx[IDX_W-1:0], pt, pv, $urandom());
  endtask

  task automatic evaluate(input logic [TIME_W-1:0] et);
    send(OP_EVAL, IDX_W'($urandom()), $urandom(), VAL_W'($urandom()), et);
  endtask

  // drain results, then let any write item finish, before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_rate();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return CFG_W'($urandom_range(0, 1 << 20));
      default: return CFG_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_depth();
    case ($urandom_range(0, 4))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'd65536;
      default: return CFG_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [TIME_W-1:0] t, t_end;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table once, so no unwritten slot is ever read
    for (int i = 0; i < MAX_POINTS; i++) begin
      t = (i == MAX_POINTS - 1) ? 32'hFFFF_FFFF : i * 32'h0F00_0000 + 32'h100;
      write_point(i, t, (i % 2) ? 24'h800000 : 24'h7FFFFF);
    end
    // reset setting: sine, phase zero, far end, quadrant edge
    evaluate('0);
    evaluate(32'hFFFF_FFFF);
    evaluate(32'h0000_4000);
    settle();

    // envelope: before, between and at the points; empty, single, over-full
    reg_write(CFG_SOURCE_KIND, 24'd1);
    reg_write(CFG_POINT_COUNT, 24'd16);
    reg_write(CFG_IDX_SPARE, 24'hFFFFFF);
    evaluate('0);
    evaluate(32'h1780_0000);
    evaluate(32'h0F00_0100);
    evaluate(32'hFFFF_FFFF);
    settle();
    reg_write(CFG_POINT_COUNT, 24'd0);
    evaluate(32'h1234_5678);
    settle();
    reg_write(CFG_POINT_COUNT, 24'd1);
    evaluate(32'hFFFF_0000);
    settle();
    reg_write(CFG_POINT_COUNT, 24'd31);
    evaluate(32'h8000_0000);
    settle();

    // random settings, one per phase; the last phases run without idling
    for (int ph = 0; ph < 24; ph++) begin
      int kind, sent;
      idle_en = (ph < 20);
      kind = $urandom_range(0, 1);
      reg_write(CFG_SOURCE_KIND, CFG_W'(kind));
      reg_write(CFG_WAVE_SHAPE, CFG_W'($urandom_range(0, 3)));
      reg_write(CFG_LFO_RATE, pick_rate());
      reg_write(CFG_LFO_DEPTH, pick_depth());
      reg_write(CFG_POINT_COUNT, CFG_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 31)
                                                                    : $urandom_range(2, 16)));
      sent = 0;
      t_end = 32'hFFFF_FFFF;
      // mostly a sorted table with random content, sometimes scrambled
      if (kind == 1 && $urandom_range(0, 3) != 0) begin
        bit scramble;
        scramble = ($urandom_range(0, 4) == 0);
        t = $urandom_range(0, 1000);
        for (int i = 0; i < MAX_POINTS; i++) begin
          write_point(i, scramble ? $urandom() : t, VAL_W'($urandom()));
          t_end = t;
          t += $urandom_range(1, 1 << 27);
          sent++;
        end
      end
      while (sent < 80) begin
        case ($urandom_range(0, 9))
          0:       write_point($urandom_range(0, 15), $urandom(), VAL_W'($urandom()));
          1, 2:    evaluate($urandom());
          default: evaluate($urandom_range(0, t_end));
        endcase
        sent++;
      end
      settle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
